// ===== src/cwsm_pkg.sv =====
package cwsm_pkg;

  localparam int unsigned TickW  = 10;
  localparam int unsigned DelayW = 16;
  localparam int unsigned LevelW = 10;
  localparam int unsigned TimeW  = 6;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TimeW-1:0] TimeMax = TimeW'(59);

  // key ladder thresholds
  localparam logic [LevelW-1:0] LvlNoneAbove = LevelW'(1000);
  localparam logic [LevelW-1:0] LvlRight     = LevelW'(50);
  localparam logic [LevelW-1:0] LvlUp        = LevelW'(195);
  localparam logic [LevelW-1:0] LvlDown      = LevelW'(380);
  localparam logic [LevelW-1:0] LvlLeft      = LevelW'(555);
  localparam logic [LevelW-1:0] LvlSelect    = LevelW'(790);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICK_MS     = 2'd0,
    CFG_KEY_POLL_MS = 2'd1,
    CFG_BLINK_MS    = 2'd2,
    CFG_SECOND_MS   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KEY_NONE,
    KEY_UP,
    KEY_LEFT,
    KEY_SELECT,
    KEY_OTHER
  } key_e;

  typedef struct packed {
    logic [TickW-1:0]  tick_ms;
    logic [DelayW-1:0] key_poll_ms;
    logic [DelayW-1:0] blink_ms;
    logic [DelayW-1:0] second_ms;
  } cfg_t;

  typedef struct packed {
    logic             set_mode;
    logic [TimeW-1:0] minutes;
    logic [TimeW-1:0] seconds;
    logic             hide_minutes;
    logic             hide_seconds;
  } res_t;

  function automatic key_e decode_key(logic [LevelW-1:0] level);
    key_e k;
    if (level > LvlNoneAbove)   k = KEY_NONE;
    else if (level < LvlRight)  k = KEY_OTHER;
    else if (level < LvlUp)     k = KEY_UP;
    else if (level < LvlDown)   k = KEY_OTHER;
    else if (level < LvlLeft)   k = KEY_LEFT;
    else if (level < LvlSelect) k = KEY_SELECT;
    else                        k = KEY_NONE;
    return k;
  endfunction

  function automatic logic [TimeW-1:0] raise_wrap(logic [TimeW-1:0] v);
    return (v >= TimeMax) ? '0 : v + TimeW'(1);
  endfunction

endpackage

// ===== src/cwsm_timer.sv =====
module cwsm_timer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           tick_i,
  input  logic [cwsm_pkg::TickW-1:0]     tick_ms_i,
  input  logic [cwsm_pkg::DelayW-1:0]    delay_i,
  input  logic                           consult_i,
  output logic                           fire_o
);

  logic [cwsm_pkg::DelayW-1:0] rem_q, rem_d, rem_tk;
  logic                        armed_q, armed_d;
  logic [cwsm_pkg::DelayW-1:0] tick_ext;

  assign tick_ext = cwsm_pkg::DelayW'(tick_ms_i);

  always_comb begin
    rem_tk = rem_q;
    if (tick_i && armed_q && (rem_q != '0)) begin
      rem_tk = (rem_q > tick_ext) ? rem_q - tick_ext : '0;
    end
    rem_d   = rem_tk;
    armed_d = armed_q;
    fire_o  = 1'b0;
    if (consult_i) begin
      if (!armed_q) begin
        rem_d   = delay_i;
        armed_d = 1'b1;
      end else if (rem_tk == '0) begin
        armed_d = 1'b0;
        fire_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      armed_q <= 1'b0;
    end else if (step_i) begin
      rem_q   <= rem_d;
      armed_q <= armed_d;
    end
  end

endmodule

// ===== src/cwsm_core.sv =====
module cwsm_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          tick_i,
  input  logic [cwsm_pkg::LevelW-1:0]   key_level_i,
  input  cwsm_pkg::cfg_t                cfg_i,
  output cwsm_pkg::res_t                res_o
);

  logic mode_q, mode_d;
  logic field_q, field_d;   // 1: editing minutes
  logic blink_q, blink_d;
  logic [cwsm_pkg::TimeW-1:0] run_m_q, run_m_d, run_s_q, run_s_d;
  logic [cwsm_pkg::TimeW-1:0] edit_m_q, edit_m_d, edit_s_q, edit_s_d;
  logic key_fire, sec_fire, blink_fire;
  cwsm_pkg::key_e key;

  cwsm_timer u_key_timer (
    .clk_i, .rst_ni, .step_i, .tick_i,
    .tick_ms_i (cfg_i.tick_ms),
    .delay_i   (cfg_i.key_poll_ms),
    .consult_i (1'b1),
    .fire_o    (key_fire)
  );

  cwsm_timer u_sec_timer (
    .clk_i, .rst_ni, .step_i, .tick_i,
    .tick_ms_i (cfg_i.tick_ms),
    .delay_i   (cfg_i.second_ms),
    .consult_i (1'b1),
    .fire_o    (sec_fire)
  );

  // blink timer only runs its load/fire logic in set mode
  cwsm_timer u_blink_timer (
    .clk_i, .rst_ni, .step_i, .tick_i,
    .tick_ms_i (cfg_i.tick_ms),
    .delay_i   (cfg_i.blink_ms),
    .consult_i (mode_q),
    .fire_o    (blink_fire)
  );

  assign key = key_fire ? cwsm_pkg::decode_key(key_level_i) : cwsm_pkg::KEY_NONE;

  always_comb begin
    mode_d   = mode_q;
    field_d  = field_q;
    blink_d  = blink_q;
    run_m_d  = run_m_q;
    run_s_d  = run_s_q;
    edit_m_d = edit_m_q;
    edit_s_d = edit_s_q;
    res_o    = '0;
    res_o.set_mode = mode_q;

    if (!mode_q) begin
      res_o.minutes = run_m_q;
      res_o.seconds = run_s_q;
      if (key == cwsm_pkg::KEY_SELECT) begin
        mode_d   = 1'b1;
        field_d  = 1'b0;
        edit_m_d = run_m_q;
        edit_s_d = run_s_q;
      end
    end else begin
      case (key)
        cwsm_pkg::KEY_UP: begin
          if (field_q) edit_m_d = cwsm_pkg::raise_wrap(edit_m_q);
          else         edit_s_d = cwsm_pkg::raise_wrap(edit_s_q);
        end
        cwsm_pkg::KEY_LEFT: field_d = !field_q;
        cwsm_pkg::KEY_SELECT: begin
          mode_d  = 1'b0;
          run_m_d = edit_m_q;
          run_s_d = edit_s_q;
        end
        default: ;
      endcase
      if (blink_fire) blink_d = !blink_q;
      res_o.minutes = edit_m_d;
      res_o.seconds = edit_s_d;
      res_o.hide_minutes = !blink_d && field_d;
      res_o.hide_seconds = !blink_d && !field_d;
    end

    // second increment sees a time just loaded by SELECT
    if (sec_fire) begin
      if (run_s_d < cwsm_pkg::TimeMax) begin
        run_s_d = run_s_d + cwsm_pkg::TimeW'(1);
      end else begin
        run_s_d = '0;
        run_m_d = cwsm_pkg::raise_wrap(run_m_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      field_q  <= 1'b0;
      blink_q  <= 1'b0;
      run_m_q  <= '0;
      run_s_q  <= '0;
      edit_m_q <= '0;
      edit_s_q <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      field_q  <= field_d;
      blink_q  <= blink_d;
      run_m_q  <= run_m_d;
      run_s_q  <= run_s_d;
      edit_m_q <= edit_m_d;
      edit_s_q <= edit_s_d;
    end
  end

endmodule

// ===== src/clock_with_set_mode_unit.sv =====
// Minutes:seconds clock with a set mode, one main-loop pass per input transfer.
// Input channel (in_valid_i/in_ready_o): tick_i flags an elapsed timer tick,
// key_level_i is the raw button ladder level. Output channel
// (out_valid_o/out_ready_i): one line per pass with the mode, the shown
// minutes and seconds and the two hide flags for the blinking field.
// A transfer loads the input register; when the result register is free or
// being read, the pass is evaluated against the clock state and lands in the
// result register. Throughput is one pass per cycle unless the receiver stalls.
// When the receiver stalls the result register holds, the input register
// holds its pass, and in_ready_o drops once both are full; nothing is lost.
// Reset (rst_ni low, asynchronous) clears both valid flags, the clock, the
// mode and the three delay timers, and loads the default delay settings.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 tick_ms,
// 1 key_poll_ms, 2 blink_ms, 3 second_ms) at the clock edge; a delay change
// affects the next timer load, tick_ms the next tick. Write only while idle.
module clock_with_set_mode_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cwsm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [cwsm_pkg::DelayW-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                tick_i,
  input  logic [cwsm_pkg::LevelW-1:0]         key_level_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                set_mode_o,
  output logic [cwsm_pkg::TimeW-1:0]          shown_minutes_o,
  output logic [cwsm_pkg::TimeW-1:0]          shown_seconds_o,
  output logic                                hide_minutes_o,
  output logic                                hide_seconds_o
);

  cwsm_pkg::cfg_t cfg_q;
  logic           in_valid_q;
  logic           tick_q;
  logic [cwsm_pkg::LevelW-1:0] key_q;
  logic           out_valid_q;
  cwsm_pkg::res_t res_q, res_d;
  logic           advance, step;

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_ms     <= cwsm_pkg::TickW'(50);
      cfg_q.key_poll_ms <= cwsm_pkg::DelayW'(150);
      cfg_q.blink_ms    <= cwsm_pkg::DelayW'(500);
      cfg_q.second_ms   <= cwsm_pkg::DelayW'(1000);
    end else if (cfg_we_i) begin
      unique case (cwsm_pkg::cfg_idx_e'(cfg_idx_i))
        cwsm_pkg::CFG_TICK_MS:     cfg_q.tick_ms     <= cfg_data_i[cwsm_pkg::TickW-1:0];
        cwsm_pkg::CFG_KEY_POLL_MS: cfg_q.key_poll_ms <= cfg_data_i;
        cwsm_pkg::CFG_BLINK_MS:    cfg_q.blink_ms    <= cfg_data_i;
        cwsm_pkg::CFG_SECOND_MS:   cfg_q.second_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance)    out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tick_q <= tick_i;
      key_q  <= key_level_i;
    end
    if (step) res_q <= res_d;
  end

  cwsm_core u_core (
    .clk_i,
    .rst_ni,
    .step_i      (step),
    .tick_i      (tick_q),
    .key_level_i (key_q),
    .cfg_i       (cfg_q),
    .res_o       (res_d)
  );

  assign out_valid_o     = out_valid_q;
  assign set_mode_o      = res_q.set_mode;
  assign shown_minutes_o = res_q.minutes;
  assign shown_seconds_o = res_q.seconds;
  assign hide_minutes_o  = res_q.hide_minutes;
  assign hide_seconds_o  = res_q.hide_seconds;

endmodule
